@@ rtl/haversine_great_circle_distance_unit_defines.svh @@
// Assertion macros for the haversine distance unit checker
`ifndef HAVERSINE_GREAT_CIRCLE_DISTANCE_UNIT_DEFINES_SVH
`define HAVERSINE_GREAT_CIRCLE_DISTANCE_UNIT_DEFINES_SVH

`define HGC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hgc checker: implication failed");

`define HGC_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("hgc checker: invariant failed");

`endif

@@ rtl/hgc_pkg.sv @@
// Shared constants, types and CORDIC table for the haversine distance unit
package hgc_pkg;

  localparam int DEG_W = 27;
  localparam int MAG_W = 24;
  localparam int Q30_W = 33;

  localparam logic signed [DEG_W-1:0] FULL_Q17    = 27'sd47185920;
  localparam logic signed [DEG_W-1:0] HALF_Q17    = 27'sd23592960;
  localparam logic signed [DEG_W-1:0] QUARTER_Q17 = 27'sd11796480;

  localparam logic [26:0] DEG2RAD_Q32 = 27'd74961321;
  localparam logic signed [Q30_W-1:0] CORDIC_START = 33'sd652032874;
  localparam logic [30:0] ONE_Q30 = 31'd1073741824;
  localparam logic [23:0] DIST_MAX = 24'hFFFFFF;
  localparam logic [15:0] RADIUS_RESET = 16'd6371;

  typedef logic signed [DEG_W-1:0] deg_t;
  typedef logic signed [Q30_W-1:0] q30_t;

  localparam logic [31:0] ATAN_Q32 [32] = '{
    32'd3373259426, 32'd1991351318, 32'd1052175347, 32'd534100634,
    32'd268086748,  32'd134174064,  32'd67103403,   32'd33553749,
    32'd16777131,   32'd8388597,    32'd4194303,    32'd2097152,
    32'd1048576,    32'd524288,     32'd262144,     32'd131072,
    32'd65536,      32'd32768,      32'd16384,      32'd8192,
    32'd4096,       32'd2048,       32'd1024,       32'd512,
    32'd256,        32'd128,        32'd64,         32'd32,
    32'd16,         32'd8,          32'd4,          32'd2
  };

  function automatic logic [32:0] atan_round(int idx, int frac);
    logic [63:0] t;
    t = 64'(ATAN_Q32[idx[4:0]]) + (64'd1 << (31 - frac));
    return 33'(t >> (32 - frac));
  endfunction

endpackage

@@ rtl/haversine_great_circle_distance_unit.sv @@
// Top level of the haversine great-circle distance unit
//
// One coordinate pair may be started in every clock cycle; busy stays low.
// Each distance appears on distance with done high for one cycle; its
// latency is set by the two CORDIC pipelines and the 32-stage square
// root. The result cannot be held off, so capture it when done is high.
// The radius is written through cfg_valid/cfg_ready, always ready, and
// should change only while no pair is in flight.
module haversine_great_circle_distance_unit #(
  parameter int ANGLE_FRACTION_BITS = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [23:0] start_latitude,
  input  logic signed [24:0] start_longitude,
  input  logic signed [23:0] end_latitude,
  input  logic signed [24:0] end_longitude,
  output logic               done,
  output logic [23:0]        distance,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        sphere_radius_km
);
  localparam int LATENCY = 2 * CORDIC_STEPS + 43;
  localparam int DW = hgc_pkg::DEG_W;
  localparam int ZW = ANGLE_FRACTION_BITS + 3;
  localparam int PW = 16 + ZW;
  localparam logic [PW:0] RND = (PW+1)'(1) << (ANGLE_FRACTION_BITS - 5);

  logic [15:0] radius;
  logic [LATENCY-1:0] vpipe;

  hgc_pkg::deg_t d_lat, d_lon, lat1_x2, lat2_x2;
  hgc_pkg::q30_t sd, sl, c1, c2;

  logic signed [65:0] p_sd, p_sl, p_cc, p_t;
  hgc_pkg::q30_t sq1, sq2, cc, sq1_d, t;
  logic signed [33:0] a_sum;
  logic [30:0] a;
  logic [30:0] a_comp;
  logic [30:0] sa, sb;
  logic signed [ZW-1:0] z;
  logic [ZW-1:0] theta;
  logic [PW-1:0] prod;
  logic [PW:0] dist_sum;
  logic [PW:0] dist_q;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= hgc_pkg::RADIUS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      radius <= sphere_radius_km;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else begin
      vpipe <= {vpipe[LATENCY-2:0], start && !busy};
    end
  end

  always_ff @(posedge clk) begin
    d_lat   <= DW'(end_latitude) - DW'(start_latitude);
    d_lon   <= DW'(end_longitude) - DW'(start_longitude);
    lat1_x2 <= DW'(start_latitude) <<< 1;
    lat2_x2 <= DW'(end_latitude) <<< 1;
  end

  hgc_sincos #(.ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS), .CORDIC_STEPS(CORDIC_STEPS))
    u_sc_dlat (.clk(clk), .angle(d_lat), .sin_q(sd), .cos_q());
  hgc_sincos #(.ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS), .CORDIC_STEPS(CORDIC_STEPS))
    u_sc_dlon (.clk(clk), .angle(d_lon), .sin_q(sl), .cos_q());
  hgc_sincos #(.ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS), .CORDIC_STEPS(CORDIC_STEPS))
    u_sc_lat1 (.clk(clk), .angle(lat1_x2), .sin_q(), .cos_q(c1));
  hgc_sincos #(.ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS), .CORDIC_STEPS(CORDIC_STEPS))
    u_sc_lat2 (.clk(clk), .angle(lat2_x2), .sin_q(), .cos_q(c2));

  assign p_sd = 66'(sd) * 66'(sd);
  assign p_sl = 66'(sl) * 66'(sl);
  assign p_cc = 66'(c1) * 66'(c2);

  always_ff @(posedge clk) begin
    sq1 <= hgc_pkg::Q30_W'(p_sd >>> 30);
    sq2 <= hgc_pkg::Q30_W'(p_sl >>> 30);
    cc  <= hgc_pkg::Q30_W'(p_cc >>> 30);
  end

  assign p_t = 66'(cc) * 66'(sq2);

  always_ff @(posedge clk) begin
    t     <= hgc_pkg::Q30_W'(p_t >>> 30);
    sq1_d <= sq1;
  end

  assign a_sum = 34'(sq1_d) + 34'(t);

  always_ff @(posedge clk) begin
    priority if (a_sum < 0) begin
      a <= '0;
    end else if (a_sum > $signed({3'b000, hgc_pkg::ONE_Q30})) begin
      a <= hgc_pkg::ONE_Q30;
    end else begin
      a <= a_sum[30:0];
    end
  end

  assign a_comp = hgc_pkg::ONE_Q30 - a;

  hgc_sqrt u_sqrt_a (.clk(clk), .radicand({a, 30'b0}), .root(sa));
  hgc_sqrt u_sqrt_b (.clk(clk), .radicand({a_comp, 30'b0}), .root(sb));

  hgc_atan #(.ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS), .CORDIC_STEPS(CORDIC_STEPS))
    u_atan (.clk(clk), .y_in(sa), .x_in(sb), .angle(z));

  assign theta = (z < 0) ? '0 : ZW'(z <<< 1);

  always_ff @(posedge clk) begin
    prod <= PW'(radius) * PW'(theta);
  end

  assign dist_sum = (PW+1)'(prod) + RND;
  assign dist_q   = dist_sum >> (ANGLE_FRACTION_BITS - 4);

  always_ff @(posedge clk) begin
    if (dist_q > (PW+1)'(hgc_pkg::DIST_MAX)) begin
      distance <= hgc_pkg::DIST_MAX;
    end else begin
      distance <= dist_q[23:0];
    end
  end

  assign done = vpipe[LATENCY-1];

endmodule

@@ rtl/hgc_sincos.sv @@
// Angle folding, degree to radian scaling and rotation CORDIC pipeline
module hgc_sincos #(
  parameter int ANGLE_FRACTION_BITS = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic          clk,
  input  hgc_pkg::deg_t angle,
  output hgc_pkg::q30_t sin_q,
  output hgc_pkg::q30_t cos_q
);
  localparam int ZW = ANGLE_FRACTION_BITS + 3;
  localparam int XW = hgc_pkg::Q30_W;
  localparam int PW = 51;
  localparam int SH = 49 - ANGLE_FRACTION_BITS;
  localparam logic [PW-1:0] RND = PW'(1) << (SH - 1);

  hgc_pkg::deg_t r_fold;
  logic          negc_c;
  logic [hgc_pkg::MAG_W-1:0] mag_c;

  logic [hgc_pkg::MAG_W-1:0] s0_mag;
  logic s0_neg, s0_negc;
  logic [PW-1:0] s1_prod;
  logic s1_neg, s1_negc;
  logic [PW-1:0] zr;

  logic signed [XW-1:0] x_q [0:CORDIC_STEPS];
  logic signed [XW-1:0] y_q [0:CORDIC_STEPS];
  logic signed [ZW-1:0] z_q [0:CORDIC_STEPS];
  logic                 nc_q [0:CORDIC_STEPS];

  always_comb begin
    r_fold = angle;
    negc_c = 1'b0;
    priority if (r_fold > hgc_pkg::HALF_Q17) begin
      r_fold = r_fold - hgc_pkg::FULL_Q17;
    end else if (r_fold <= -hgc_pkg::HALF_Q17) begin
      r_fold = r_fold + hgc_pkg::FULL_Q17;
    end else begin
      r_fold = r_fold;
    end
    priority if (r_fold > hgc_pkg::QUARTER_Q17) begin
      r_fold = hgc_pkg::HALF_Q17 - r_fold;
      negc_c = 1'b1;
    end else if (r_fold < -hgc_pkg::QUARTER_Q17) begin
      r_fold = -hgc_pkg::HALF_Q17 - r_fold;
      negc_c = 1'b1;
    end else begin
      r_fold = r_fold;
    end
    mag_c = (r_fold < 0) ? hgc_pkg::MAG_W'(-r_fold) : hgc_pkg::MAG_W'(r_fold);
  end

  always_ff @(posedge clk) begin
    s0_mag  <= mag_c;
    s0_neg  <= r_fold < 0;
    s0_negc <= negc_c;
  end

  always_ff @(posedge clk) begin
    s1_prod <= PW'(s0_mag) * PW'(hgc_pkg::DEG2RAD_Q32);
    s1_neg  <= s0_neg;
    s1_negc <= s0_negc;
  end

  assign zr = (s1_prod + RND) >> SH;

  always_ff @(posedge clk) begin
    x_q[0]  <= hgc_pkg::CORDIC_START;
    y_q[0]  <= '0;
    z_q[0]  <= s1_neg ? -ZW'(zr) : ZW'(zr);
    nc_q[0] <= s1_negc;
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    localparam logic signed [ZW-1:0] ATN = ZW'(hgc_pkg::atan_round(i, ANGLE_FRACTION_BITS));
    always_ff @(posedge clk) begin
      if (z_q[i] >= 0) begin
        x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] - ATN;
      end else begin
        x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] + ATN;
      end
      nc_q[i+1] <= nc_q[i];
    end
  end

  always_ff @(posedge clk) begin
    sin_q <= y_q[CORDIC_STEPS];
    cos_q <= nc_q[CORDIC_STEPS] ? -x_q[CORDIC_STEPS] : x_q[CORDIC_STEPS];
  end

endmodule

@@ rtl/hgc_sqrt.sv @@
// Pipelined floor square root, one root bit per stage
module hgc_sqrt (
  input  logic        clk,
  input  logic [60:0] radicand,
  output logic [30:0] root
);
  localparam int STAGES = 31;

  logic [60:0] v_q [0:STAGES];
  logic [61:0] r_q [0:STAGES];

  always_ff @(posedge clk) begin
    v_q[0] <= radicand;
    r_q[0] <= '0;
  end

  for (genvar j = 0; j < STAGES; j++) begin : g_bit
    localparam logic [61:0] BIT = 62'd1 << (2 * (STAGES - 1 - j));
    logic [61:0] trial;
    assign trial = r_q[j] + BIT;
    always_ff @(posedge clk) begin
      if ({1'b0, v_q[j]} >= trial) begin
        v_q[j+1] <= v_q[j] - trial[60:0];
        r_q[j+1] <= (r_q[j] >> 1) + BIT;
      end else begin
        v_q[j+1] <= v_q[j];
        r_q[j+1] <= r_q[j] >> 1;
      end
    end
  end

  assign root = r_q[STAGES][30:0];

endmodule

@@ rtl/hgc_atan.sv @@
// Vectoring CORDIC pipeline for the first-quadrant arctangent
module hgc_atan #(
  parameter int ANGLE_FRACTION_BITS = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                                  clk,
  input  logic [30:0]                           y_in,
  input  logic [30:0]                           x_in,
  output logic signed [ANGLE_FRACTION_BITS+2:0] angle
);
  localparam int ZW = ANGLE_FRACTION_BITS + 3;
  localparam int XW = 34;

  logic signed [XW-1:0] x_q [0:CORDIC_STEPS];
  logic signed [XW-1:0] y_q [0:CORDIC_STEPS];
  logic signed [ZW-1:0] z_q [0:CORDIC_STEPS];

  always_ff @(posedge clk) begin
    x_q[0] <= $signed({3'b000, x_in});
    y_q[0] <= $signed({3'b000, y_in});
    z_q[0] <= '0;
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    localparam logic signed [ZW-1:0] ATN = ZW'(hgc_pkg::atan_round(i, ANGLE_FRACTION_BITS));
    always_ff @(posedge clk) begin
      if (y_q[i] >= 0) begin
        x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] + ATN;
      end else begin
        x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] - ATN;
      end
    end
  end

  assign angle = z_q[CORDIC_STEPS];

endmodule

@@ rtl/hgc_checker.sv @@
// Port-level checker for the haversine distance unit, bound to the top level
`include "haversine_great_circle_distance_unit_defines.svh"

module hgc_checker #(
  parameter int LATENCY = 75
) (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic cfg_valid,
  input logic cfg_ready
);

  `HGC_ASSERT_IMPL(a_done_has_start, done, $past(start, LATENCY) && !$past(busy, LATENCY))
  `HGC_ASSERT_IMPL(a_reset_flushes, $past(rst), !done)
  `HGC_ASSERT_ALWAYS(a_cfg_always_ready, !cfg_valid || cfg_ready)

endmodule

bind haversine_great_circle_distance_unit hgc_checker #(.LATENCY(LATENCY)) u_hgc_checker (
  .clk(clk),
  .rst(rst),
  .start(start),
  .busy(busy),
  .done(done),
  .cfg_valid(cfg_valid),
  .cfg_ready(cfg_ready)
);

@@ sim/tb_haversine_great_circle_distance_unit.sv @@
// Testbench for the haversine distance unit: directed and random pairs, scoreboard checked
module tb_haversine_great_circle_distance_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 16;
  localparam int STEPS = 16;
  localparam int LATENCY = 2 * STEPS + 43;

  class distance_scoreboard;
    longint unsigned expected_distance[$];
    longint unsigned radius_km;
    int errors;

    function new();
      radius_km = hgc_pkg::RADIUS_RESET;
      errors = 0;
    endfunction

    function longint arctan_step(int i);
      return longint'((64'(hgc_pkg::ATAN_Q32[i]) + (64'd1 << (31 - FRAC))) >> (32 - FRAC));
    endfunction

    function void sin_cos(longint ang, output longint s, output longint c);
      longint r, z, x, y, mag, dx, dy;
      bit flip_cos;
      r = ang % 64'sd47185920;
      flip_cos = 0;
      if (r > 64'sd23592960) r -= 64'sd47185920;
      else if (r <= -64'sd23592960) r += 64'sd47185920;
      if (r > 64'sd11796480) begin
        r = 64'sd23592960 - r;
        flip_cos = 1;
      end else if (r < -64'sd11796480) begin
        r = -64'sd23592960 - r;
        flip_cos = 1;
      end
      mag = (r < 0) ? -r : r;
      z = (mag * 74961321 + (64'sd1 << (48 - FRAC))) >>> (49 - FRAC);
      if (r < 0) z = -z;
      x = 652032874;
      y = 0;
      for (int i = 0; i < STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= arctan_step(i);
        end else begin
          x += dx; y -= dy; z += arctan_step(i);
        end
      end
      s = y;
      c = flip_cos ? -x : x;
    endfunction

    function longint vector_angle(longint y, longint x);
      longint z, dx, dy;
      z = 0;
      for (int i = 0; i < STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x += dx; y -= dy; z += arctan_step(i);
        end else begin
          x -= dx; y += dy; z -= arctan_step(i);
        end
      end
      return z;
    endfunction

    function longint unsigned floor_root(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function void note_pair(logic signed [23:0] lat1, logic signed [24:0] lon1,
                            logic signed [23:0] lat2, logic signed [24:0] lon2);
      longint sd, cd, sl, cl, s1, c1, s2, c2, hav, theta;
      longint unsigned predicted;
      sin_cos(longint'(lat2) - longint'(lat1), sd, cd);
      sin_cos(longint'(lon2) - longint'(lon1), sl, cl);
      sin_cos(longint'(lat1) * 2, s1, c1);
      sin_cos(longint'(lat2) * 2, s2, c2);
      hav = ((sd * sd) >>> 30) + ((((c1 * c2) >>> 30) * ((sl * sl) >>> 30)) >>> 30);
      if (hav < 0) hav = 0;
      if (hav > 64'sd1073741824) hav = 64'sd1073741824;
      theta = 2 * vector_angle(longint'(floor_root(longint'(hav) << 30)),
                               longint'(floor_root((64'sd1073741824 - hav) << 30)));
      if (theta < 0) theta = 0;
      predicted = (radius_km * longint'(theta) + (64'd1 << (FRAC - 5))) >> (FRAC - 4);
      if (predicted > 64'(hgc_pkg::DIST_MAX)) predicted = hgc_pkg::DIST_MAX;
      expected_distance.push_back(predicted);
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_distance(logic [23:0] got);
      longint unsigned want;
      if (expected_distance.size() == 0) begin
        report($sformatf("unexpected distance %0d", got));
      end else begin
        want = expected_distance.pop_front();
        if (got !== want[23:0]) report($sformatf("distance %0d, expected %0d", got, want));
      end
    endtask
  endclass

  logic clk, rst, start, busy, done, cfg_valid, cfg_ready;
  logic signed [23:0] start_latitude, end_latitude;
  logic signed [24:0] start_longitude, end_longitude;
  logic [23:0] distance;
  logic [15:0] sphere_radius_km;
  distance_scoreboard sb;
  int idle_pct;

  haversine_great_circle_distance_unit u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .start_latitude(start_latitude), .start_longitude(start_longitude),
    .end_latitude(end_latitude), .end_longitude(end_longitude),
    .done(done), .distance(distance),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .sphere_radius_km(sphere_radius_km)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("tb_haversine_great_circle_distance_unit failed");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy)
        sb.note_pair(start_latitude, start_longitude, end_latitude, end_longitude);
      if (done) sb.check_distance(distance);
    end
  end

  task send_pair(logic signed [23:0] lat1, logic signed [24:0] lon1,
                 logic signed [23:0] lat2, logic signed [24:0] lon2);
    @(negedge clk);
    start <= 1;
    start_latitude <= lat1;
    start_longitude <= lon1;
    end_latitude <= lat2;
    end_longitude <= lon2;
    while (busy) begin
      @(posedge clk);
      @(negedge clk);
    end
    @(posedge clk);
    if ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      start <= 0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task drain();
    @(negedge clk);
    start <= 0;
    while (sb.expected_distance.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task write_radius(logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1;
    sphere_radius_km <= value;
    while (!cfg_ready) begin
      @(posedge clk);
      @(negedge clk);
    end
    @(posedge clk);
    sb.radius_km = value;
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  function automatic logic signed [23:0] rand_lat();
    if ($urandom_range(0, 9) == 0) return 24'($urandom);
    return 24'($signed($urandom_range(0, 11796480)) - 5898240);
  endfunction

  function automatic logic signed [24:0] rand_lon();
    if ($urandom_range(0, 9) == 0) return 25'($urandom);
    return 25'($signed($urandom_range(0, 23592960)) - 11796480);
  endfunction

  task random_phase(int count);
    for (int n = 0; n < count; n++) begin
      if (n == count / 2 && idle_pct == 6) drain();
      send_pair(rand_lat(), rand_lon(), rand_lat(), rand_lon());
    end
    drain();
  endtask

  initial begin
    sb = new();
    rst = 1;
    start = 0;
    cfg_valid = 0;
    sphere_radius_km = hgc_pkg::RADIUS_RESET;
    start_latitude = 0;
    start_longitude = 0;
    end_latitude = 0;
    end_longitude = 0;
    idle_pct = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 0;

    send_pair(0, 0, 0, 0);
    send_pair(0, 0, 0, 11796480);
    send_pair(0, -11796480, 0, 11796480);
    send_pair(5898240, 0, -5898240, 0);
    send_pair(5898240, 1234567, 5898240, -7654321);
    send_pair(-5898240, 0, 0, 0);
    send_pair(24'sh7FFFFF, 25'sh0FFFFFF, -24'sh800000, -25'sh1000000);
    send_pair(-24'sh800000, -25'sh1000000, 24'sh7FFFFF, 25'sh0FFFFFF);
    send_pair(24'hFFFFFF, 25'h1FFFFFF, 0, 0);
    send_pair(3355443, 1000000, 3355444, 1000001);
    send_pair(3000000, 0, 3000000, 0);
    send_pair(0, 11796480, 0, -11796480);
    send_pair(2621440, 9830400, -2621440, -1966080);
    send_pair(7000000, 0, -7000000, 11796480);
    drain();

    write_radius(16'hFFFF);
    send_pair(0, 0, 0, 11796480);
    send_pair(5898240, 0, -5898240, 0);
    send_pair(24'sh7FFFFF, 0, -24'sh800000, 25'sh0FFFFFF);
    drain();
    write_radius(16'd0);
    send_pair(0, 0, 0, 11796480);
    send_pair(1000000, 2000000, -3000000, -4000000);
    drain();
    write_radius(16'd1);
    send_pair(0, 0, 0, 11796480);
    drain();

    idle_pct = 6;
    write_radius(hgc_pkg::RADIUS_RESET);
    random_phase(700);
    idle_pct = 47;
    write_radius(16'($urandom_range(1, 65535)));
    random_phase(400);
    idle_pct = 0;
    write_radius(16'hFFFF);
    random_phase(500);
    write_radius(16'd1);
    random_phase(200);
    write_radius(16'($urandom));
    random_phase(200);

    if (sb.errors == 0 && sb.expected_distance.size() == 0) begin
      $display("tb_haversine_great_circle_distance_unit passed");
    end else begin
      $display("tb_haversine_great_circle_distance_unit failed");
    end
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+rtl
rtl/hgc_pkg.sv
rtl/hgc_sincos.sv
rtl/hgc_sqrt.sv
rtl/hgc_atan.sv
rtl/haversine_great_circle_distance_unit.sv
rtl/hgc_checker.sv
sim/tb_haversine_great_circle_distance_unit.sv
